// ===== src/assert_macros.svh =====
// Assertion macros used by the back end of the frame ring.
// Defining ASSERT_OFF empties every macro.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/mrar_pkg.sv =====
`default_nettype none

package mrar_pkg;

  // Ring geometry and tap count.
  parameter int RingFrames  = 1024;
  parameter int Taps        = 4;
  parameter int ChunkFrames = 64;

  parameter int AddrW    = $clog2(RingFrames);
  parameter int RunW     = $clog2(ChunkFrames + 1);
  parameter int TapIdxW  = (Taps > 1) ? $clog2(Taps) : 1;
  parameter int CountW   = 32;
  parameter int SampleW  = 16;
  parameter int StartW   = 10;
  parameter int TapFldW  = 2;
  parameter int ActiveW  = 3;
  parameter int CfgW     = 3;
  parameter int CfgIdxW  = 1;

  parameter int QueueDepth = 2;
  parameter int QPtrW      = $clog2(QueueDepth);
  parameter int QCntW      = $clog2(QueueDepth + 1);

  // Command codes of the input channel.
  parameter logic CmdWrite = 1'b0;
  parameter logic CmdTake  = 1'b1;

  // Configuration register indexes.
  parameter logic [CfgIdxW-1:0] RegActiveTaps = 1'b0;
  parameter logic [CfgIdxW-1:0] RegMonoMode   = 1'b1;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic                      is_write;
    logic [AddrW-1:0]          addr;
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
    logic [RunW-1:0]           run;
  } cmd_t;

  // One result beat held in the output queue.
  typedef struct packed {
    logic [RunW-1:0]           run_length;
    logic [StartW-1:0]         run_start;
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
    logic                      last;
  } res_t;

endpackage

`default_nettype wire

// ===== src/mrar_if.sv =====
`default_nettype none

interface mrar_in_if;
  logic                                        valid;
  logic                                        ready;
  logic                                        cmd;
  logic signed [mrar_pkg::SampleW-1:0]         left_in;
  logic signed [mrar_pkg::SampleW-1:0]         right_in;
  logic [mrar_pkg::TapFldW-1:0]                tap_index;

  modport source(output valid, cmd, left_in, right_in, tap_index, input ready);
  modport sink(input valid, cmd, left_in, right_in, tap_index, output ready);
endinterface

interface mrar_out_if;
  logic                                        valid;
  logic                                        ready;
  logic [mrar_pkg::RunW-1:0]                   run_length;
  logic [mrar_pkg::StartW-1:0]                 run_start;
  logic signed [mrar_pkg::SampleW-1:0]         left_out;
  logic signed [mrar_pkg::SampleW-1:0]         right_out;
  logic                                        last;

  modport source(output valid, run_length, run_start, left_out, right_out, last,
                 input ready);
  modport sink(input valid, run_length, run_start, left_out, right_out, last,
               output ready);
endinterface

`default_nettype wire

// ===== src/mrar_front.sv =====
`default_nettype none

// Accepts items, keeps the write and tap counts and turns each item into a
// ready-to-run command for the back end.
module mrar_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  mrar_in_if.sink                            item_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [mrar_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mrar_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                          full_i,
  output logic                               push_o,
  output mrar_pkg::cmd_t                     cmd_o
);

  logic [mrar_pkg::ActiveW-1:0] active_q;
  logic                         mono_q;
  logic [mrar_pkg::CountW-1:0]  wc_q, wc_d;
  logic [mrar_pkg::CountW-1:0]  trc_q [mrar_pkg::Taps];
  logic [mrar_pkg::CountW-1:0]  trc_d [mrar_pkg::Taps];

  logic                         accept;
  logic [mrar_pkg::TapIdxW-1:0] tap_sel;
  logic                         tap_ok;
  logic [mrar_pkg::CountW-1:0]  avail;
  logic [mrar_pkg::AddrW-1:0]   start;
  logic [mrar_pkg::AddrW:0]     to_end;
  logic [mrar_pkg::RunW-1:0]    lim;
  logic [mrar_pkg::RunW-1:0]    run;

  assign item_i.ready = !full_i;
  assign accept       = item_i.valid && !full_i;

  assign tap_sel = mrar_pkg::TapIdxW'(item_i.tap_index);
  assign tap_ok  = int'(item_i.tap_index) < mrar_pkg::Taps;

  // Run length: pending frames, clipped at the chunk size and the ring end.
  always_comb begin
    avail  = wc_q - trc_q[tap_sel];
    start  = trc_q[tap_sel][mrar_pkg::AddrW-1:0];
    to_end = (mrar_pkg::AddrW + 1)'(mrar_pkg::RingFrames) - {1'b0, start};
    if (avail >= mrar_pkg::CountW'(mrar_pkg::ChunkFrames)) begin
      lim = mrar_pkg::RunW'(mrar_pkg::ChunkFrames);
    end else begin
      lim = avail[mrar_pkg::RunW-1:0];
    end
    if (mrar_pkg::CountW'(to_end) < mrar_pkg::CountW'(lim)) begin
      run = mrar_pkg::RunW'(to_end);
    end else begin
      run = lim;
    end
  end

  always_comb begin
    wc_d   = wc_q;
    trc_d  = trc_q;
    push_o = 1'b0;
    cmd_o  = '0;
    if (accept) begin
      push_o = 1'b1;
      if (item_i.cmd == mrar_pkg::CmdWrite) begin
        cmd_o.is_write = 1'b1;
        cmd_o.addr     = wc_q[mrar_pkg::AddrW-1:0];
        cmd_o.left     = item_i.left_in;
        cmd_o.right    = mono_q ? item_i.left_in : item_i.right_in;
        wc_d           = wc_q + mrar_pkg::CountW'(1);
        // Protected taps that would fall more than a ring behind move on.
        for (int t = 0; t < mrar_pkg::Taps; t++) begin
          if ((t < int'(active_q)) &&
              ((wc_d - trc_q[t]) > mrar_pkg::CountW'(mrar_pkg::RingFrames))) begin
            trc_d[t] = trc_q[t] + mrar_pkg::CountW'(1);
          end
        end
      end else if (tap_ok) begin
        cmd_o.run  = run;
        cmd_o.addr = (run == '0) ? '0 : start;
        trc_d[tap_sel] = trc_q[tap_sel] + mrar_pkg::CountW'(run);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= mrar_pkg::ActiveW'(1);
      mono_q   <= 1'b0;
      wc_q     <= '0;
      for (int t = 0; t < mrar_pkg::Taps; t++) begin
        trc_q[t] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mrar_pkg::RegActiveTaps: active_q <= cfg_data_i[mrar_pkg::ActiveW-1:0];
          mrar_pkg::RegMonoMode:   mono_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      wc_q  <= wc_d;
      trc_q <= trc_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/mrar_cmd_queue.sv =====
`default_nettype none

// Short command queue between the front and the back end.
module mrar_cmd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire mrar_pkg::cmd_t data_i,
  input  wire logic           pop_i,
  output mrar_pkg::cmd_t      head_o,
  output logic                valid_o,
  output logic                full_o
);

  mrar_pkg::cmd_t                entry_q [mrar_pkg::QueueDepth];
  logic [mrar_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [mrar_pkg::QCntW-1:0]    cnt_q;
  logic                          do_push, do_pop;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == mrar_pkg::QCntW'(mrar_pkg::QueueDepth);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + mrar_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + mrar_pkg::QPtrW'(1);
      end
      cnt_q <= cnt_q + mrar_pkg::QCntW'(do_push) - mrar_pkg::QCntW'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== src/mrar_back.sv =====
`default_nettype none

`include "assert_macros.svh"

// Executes commands against the frame memory and streams the result beats
// through a two-entry output queue.
module mrar_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mrar_pkg::cmd_t head_i,
  input  wire logic           head_valid_i,
  output logic                pop_o,
  mrar_out_if.source          res_o
);

  logic [2*mrar_pkg::SampleW-1:0] mem_q [mrar_pkg::RingFrames];
  logic [2*mrar_pkg::SampleW-1:0] rd_q;

  logic [mrar_pkg::RunW-1:0]  idx_q, idx_d, idx_inc;
  logic                       s1_valid_q;
  logic [mrar_pkg::RunW-1:0]  s1_run_q;
  logic [mrar_pkg::AddrW-1:0] s1_start_q;
  logic                       s1_last_q;
  logic                       s1_zero_q;

  mrar_pkg::res_t ofifo_q [2];
  mrar_pkg::res_t push_data;
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic [1:0]     occ;

  logic                       out_pop, issue_ok, take_pend, issue, mem_we, last_beat;
  logic [mrar_pkg::AddrW-1:0] raddr;

  assign out_pop   = res_o.valid && res_o.ready;
  assign occ       = cnt_q + {1'b0, s1_valid_q};
  // A read is issued only when its beat is sure of a place in the queue.
  assign issue_ok  = (occ < 2'd2) || out_pop;
  assign mem_we    = head_valid_i && head_i.is_write;
  assign take_pend = head_valid_i && !head_i.is_write;
  assign issue     = take_pend && issue_ok;
  assign idx_inc   = idx_q + mrar_pkg::RunW'(1);
  assign last_beat = (head_i.run == '0) || (idx_inc == head_i.run);
  assign pop_o     = mem_we || (issue && last_beat);
  assign raddr     = head_i.addr + mrar_pkg::AddrW'(idx_q);

  always_comb begin
    idx_d = idx_q;
    if (issue) begin
      idx_d = last_beat ? '0 : idx_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[head_i.addr] <= {head_i.left, head_i.right};
    end
    if (issue) begin
      rd_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_run_q   <= head_i.run;
      s1_start_q <= head_i.addr;
      s1_last_q  <= last_beat;
      s1_zero_q  <= head_i.run == '0;
    end
  end

  always_comb begin
    push_data.run_length = s1_run_q;
    push_data.run_start  = mrar_pkg::StartW'(s1_start_q);
    push_data.left       = s1_zero_q ? '0 : rd_q[2*mrar_pkg::SampleW-1:mrar_pkg::SampleW];
    push_data.right      = s1_zero_q ? '0 : rd_q[mrar_pkg::SampleW-1:0];
    push_data.last       = s1_last_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      ofifo_q[wr_ptr_q] <= push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      cnt_q      <= '0;
    end else begin
      idx_q      <= idx_d;
      s1_valid_q <= issue;
      if (s1_valid_q) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (out_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, s1_valid_q} - {1'b0, out_pop};
    end
  end

  assign res_o.valid      = cnt_q != '0;
  assign res_o.run_length = ofifo_q[rd_ptr_q].run_length;
  assign res_o.run_start  = ofifo_q[rd_ptr_q].run_start;
  assign res_o.left_out   = ofifo_q[rd_ptr_q].left;
  assign res_o.right_out  = ofifo_q[rd_ptr_q].right;
  assign res_o.last       = ofifo_q[rd_ptr_q].last;

  `ASSERT_ALWAYS(a_credit_bound, clk_i, rst_ni, occ <= 2'd2)
  `ASSERT_ALWAYS(a_no_overflow, clk_i, rst_ni, !(s1_valid_q && cnt_q == 2'd2 && !out_pop))
  `ASSERT_IMPLIES(a_idx_in_run, clk_i, rst_ni, take_pend && head_i.run != '0, idx_q < head_i.run)
  `ASSERT_IMPLIES(a_idx_clear, clk_i, rst_ni, !head_valid_i, idx_q == '0)

endmodule

`default_nettype wire

// ===== src/multi_reader_audio_ring.sv =====
// Stereo frame ring with four reader taps.
// Input channel item_i: one beat is either a frame write (cmd write) or a
// take for one tap (cmd take). Output channel result_o carries result beats:
// a take gives one beat per frame of its run, the final one with last set,
// or a single all-zero beat with last set when the tap has nothing pending.
// Writes give no beat. Configuration writes (active taps, mono mode) go
// through cfg_we_i/cfg_idx_i/cfg_data_i and take effect at once.
// The first beat of a take passes through the command queue, the read
// register and the output queue before it is valid. Throughput: the front takes
// one item per cycle while its two-entry command queue has room; the back
// handles a write or one frame of a run (or an empty take) at a time,
// bounded by the single read port of the frame memory.
// Reset clears the counts, sets one active tap and stereo mode; the frame
// memory is not cleared, since a tap can only ever read frames written.
// When the receiver stalls, the two-entry output queue fills, the back stops
// issuing reads, the command queue fills and the input ready drops.
`default_nettype none

module multi_reader_audio_ring (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  mrar_in_if.sink                            item_i,
  mrar_out_if.source                         result_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mrar_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mrar_pkg::CfgW-1:0]     cfg_data_i
);

  // Commands flow front -> queue -> back; all count bookkeeping happens in
  // the front when an item is accepted, so the back only moves frames.
  mrar_pkg::cmd_t push_cmd;
  mrar_pkg::cmd_t head_cmd;
  logic           push, full, head_valid, pop;

  mrar_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  mrar_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .valid_o (head_valid),
    .full_o  (full)
  );

  // The back writes frames in command order, so a take always sees every
  // write accepted before it.
  mrar_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_cmd),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .res_o        (result_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/mrar_ring_check.sv =====
module mrar_ring_check (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  mrar_in_if                                 items_i,
  mrar_out_if                                results_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [mrar_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mrar_pkg::CfgW-1:0]     cfg_data_i,
  output int                                 fails_o,
  output int                                 owed_o
);
  import mrar_pkg::*;

  // Private copy of the ring, the counts and the two registers.
  logic [SampleW-1:0] ring_l [RingFrames];
  logic [SampleW-1:0] ring_r [RingFrames];
  logic [CountW-1:0]  frames_written;
  logic [CountW-1:0]  tap_pos [Taps];
  logic [ActiveW-1:0] guarded_taps;
  logic               mono;

  // Result beats that accepted takes still owe, oldest first.
  res_t owed_beats [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fails_o++;
    $display("mismatch at %0t: %s, got %0h, wanted %0h", $realtime, what, got, want);
  endtask

  task automatic store_frame(input logic [SampleW-1:0] l, input logic [SampleW-1:0] r);
    int unsigned guarded;
    int unsigned t;
    logic [AddrW-1:0] slot;
    slot = frames_written[AddrW-1:0];
    guarded = (guarded_taps > Taps) ? Taps : guarded_taps;
    ring_l[slot] = l;
    ring_r[slot] = mono ? l : r;
    frames_written = frames_written + 1'b1;
    // A guarded tap more than a whole ring behind loses its oldest frame.
    for (t = 0; t < guarded; t++) begin
      if (frames_written - tap_pos[t] > RingFrames) begin
        tap_pos[t] = tap_pos[t] + 1'b1;
      end
    end
  endtask

  task automatic plan_take(input logic [TapFldW-1:0] tap);
    logic [CountW-1:0] pending;
    int unsigned first;
    int unsigned run;
    int unsigned i;
    res_t beat;
    beat = '0;
    pending = frames_written - tap_pos[tap];
    if (pending == 0) begin
      beat.last = 1'b1;
      owed_beats.push_back(beat);
      return;
    end
    first = tap_pos[tap][AddrW-1:0];
    run = RingFrames - first;
    if (run > pending) run = pending;
    if (run > ChunkFrames) run = ChunkFrames;
    for (i = 0; i < run; i++) begin
      beat.run_length = run[RunW-1:0];
      beat.run_start  = first[StartW-1:0];
      beat.left       = ring_l[first + i];
      beat.right      = ring_r[first + i];
      beat.last       = (i + 1 == run);
      owed_beats.push_back(beat);
    end
    tap_pos[tap] = tap_pos[tap] + run;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : follow
    int i;
    res_t want;
    if (!rst_ni) begin
      for (i = 0; i < RingFrames; i++) begin
        ring_l[i] = '0;
        ring_r[i] = '0;
      end
      for (i = 0; i < Taps; i++) begin
        tap_pos[i] = '0;
      end
      frames_written = '0;
      guarded_taps = ActiveW'(1);
      mono = 1'b0;
      owed_beats.delete();
    end else begin
      // Result beats are checked before the input beat of the same edge,
      // which cannot yet have produced anything.
      if (results_i.valid && results_i.ready) begin
        if (owed_beats.size() == 0) begin
          report_mismatch("result beat with nothing owed", results_i.last, 0);
        end else begin
          want = owed_beats.pop_front();
          if (results_i.run_length !== want.run_length)
            report_mismatch("run_length", results_i.run_length, want.run_length);
          if (results_i.run_start !== want.run_start)
            report_mismatch("run_start", results_i.run_start, want.run_start);
          if (results_i.left_out !== want.left)
            report_mismatch("left_out", results_i.left_out, want.left);
          if (results_i.right_out !== want.right)
            report_mismatch("right_out", results_i.right_out, want.right);
          if (results_i.last !== want.last)
            report_mismatch("last", results_i.last, want.last);
        end
      end
      if (items_i.valid && items_i.ready) begin
        if (items_i.cmd == CmdWrite) begin
          store_frame(items_i.left_in, items_i.right_in);
        end else begin
          plan_take(items_i.tap_index);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == RegActiveTaps) begin
          guarded_taps = cfg_data_i[ActiveW-1:0];
        end else if (cfg_idx_i == RegMonoMode) begin
          mono = cfg_data_i[0];
        end
      end
    end
    owed_o = owed_beats.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the frame ring bench. This module only produces traffic and
// gives the verdict; every beat on both channels is followed and checked
// by the ring checker instantiated beside the block.
module tb;
  import mrar_pkg::*;

  // A run is abandoned when this many cycles pass without any beat moving.
  // The longest legitimate silence is the deliberate receiver hold-off.
  localparam int StallLimit   = 3000;
  localparam int HoldCycles   = 400;
  // Cycles allowed after the last owed beat for writes still inside the
  // block, which may still sit in the command queue.
  localparam int SettleCycles = 8;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;

  int fails;
  int owed;
  int send_gap_pct;
  int recv_gap_pct;
  int hold_req = 0;
  int quiet_cycles = 0;

  mrar_in_if  item_ch ();
  mrar_out_if result_ch ();

  multi_reader_audio_ring dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .item_i     (item_ch),
    .result_o   (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  mrar_ring_check ring_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .items_i    (item_ch),
    .results_i  (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .fails_o    (fails),
    .owed_o     (owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The watchdog counts edges at which no beat moved on either channel.
  always @(posedge clk) begin
    if (!rst_n || (item_ch.valid && item_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("multi_reader_audio_ring verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The receiver drops ready at random, and on each new request holds it low
  // for a long stretch, counted here, so that the output queue and then the
  // command queue fill up and the block refuses further input beats.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    result_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // Samples are mostly the extremes and the all-ones and all-zeros
  // patterns; a third are random so that every bit is toggled.
  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return SampleW'($urandom);
    endcase
  endfunction

  // Offers one input beat after a random number of idle cycles and returns
  // just after the edge at which it was accepted. Valid stays high when the
  // next beat follows without a gap.
  task automatic offer(input logic cmd, input logic [SampleW-1:0] l,
                       input logic [SampleW-1:0] r, input logic [TapFldW-1:0] tap);
    while ($urandom_range(99) < send_gap_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.cmd       <= cmd;
    item_ch.left_in   <= l;
    item_ch.right_in  <= r;
    item_ch.tap_index <= tap;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Stops offering, waits until every owed beat has arrived, then lets the
  // block finish any write it still holds. The owed count is sampled on the
  // falling edge, well away from the checker's own update.
  task automatic settle();
    item_ch.valid <= 1'b0;
    do @(negedge clk); while (owed != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Both registers are written on consecutive edges while the block is idle.
  task automatic set_config(input logic [ActiveW-1:0] taps, input logic mono);
    cfg_we   <= 1'b1;
    cfg_idx  <= RegActiveTaps;
    cfg_data <= CfgW'(taps);
    @(posedge clk);
    cfg_idx  <= RegMonoMode;
    cfg_data <= CfgW'(mono);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // One random phase: a fresh setting, fresh idling rates, then a stream of
  // writes and takes. Takes pick a tap between low_tap and the highest one.
  task automatic phase(input logic [ActiveW-1:0] taps, input logic mono,
                       input int send_pct, input int recv_pct, input bit squeeze,
                       input int items, input int take_pct, input int low_tap);
    int n;
    logic is_take;
    settle();
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    set_config(taps, mono);
    if (squeeze) hold_req++;
    for (n = 0; n < items; n++) begin
      is_take = ($urandom_range(99) < take_pct);
      offer(is_take ? CmdTake : CmdWrite, pick_sample(), pick_sample(),
            TapFldW'($urandom_range(Taps - 1, low_tap)));
    end
  endtask

  initial begin : stimulus
    item_ch.valid     = 1'b0;
    item_ch.cmd       = CmdWrite;
    item_ch.left_in   = '0;
    item_ch.right_in  = '0;
    item_ch.tap_index = '0;
    cfg_we            = 1'b0;
    cfg_idx           = RegActiveTaps;
    cfg_data          = '0;
    send_gap_pct      = 35;
    recv_gap_pct      = 69;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed start under the reset setting: one guarded tap, stereo.
    // Takes on a tap with nothing pending must give a single empty beat.
    offer(CmdTake, 16'h1234, 16'h5678, 2'd0);
    offer(CmdTake, 16'hffff, 16'hffff, 2'd3);
    // Frames at the sample extremes, then a run of four on tap 0, after
    // which that tap is empty again.
    offer(CmdWrite, 16'h8000, 16'h7fff, 2'd1);
    offer(CmdWrite, 16'h7fff, 16'h8000, 2'd2);
    offer(CmdWrite, 16'h0000, 16'hffff, 2'd3);
    offer(CmdWrite, 16'hffff, 16'h0000, 2'd0);
    offer(CmdTake, 16'h0000, 16'h0000, 2'd0);
    offer(CmdTake, 16'h0000, 16'h0000, 2'd0);
    // An unguarded tap still reads everything that is there.
    offer(CmdTake, 16'h0000, 16'h0000, 2'd1);

    // More taps asked for than exist, and mono: the right sample of each
    // new frame must repeat the left one.
    settle();
    set_config(3'd7, 1'b1);
    offer(CmdWrite, 16'h8000, 16'h7fff, 2'd0);
    offer(CmdWrite, 16'h5a5a, 16'ha5a5, 2'd3);
    offer(CmdWrite, 16'h7fff, 16'h0001, 2'd2);
    offer(CmdTake, 16'h0000, 16'h0000, 2'd2);
    offer(CmdTake, 16'h0000, 16'h0000, 2'd0);

    // Sender idling lightly, receiver heavily. The second phase begins with
    // the long receiver hold-off.
    phase(3'd0, 1'b0, 35, 69, 1'b0, 50, 35, 0);
    phase(3'd4, 1'b1, 35, 69, 1'b1, 50, 35, 0);
    // Roles swapped. The long phase is mostly writes with only occasional
    // takes on the top tap, which is unguarded here, so its takes may find
    // more than a chunk pending and be clipped at the chunk size.
    phase(3'd3, 1'b0, 69, 35, 1'b0, 146, 3, 3);
    phase(3'd2, 1'b1, 69, 35, 1'b0, 50, 35, 0);
    // No idling on either side.
    phase(3'd7, 1'b0, 0, 0, 1'b0, 50, 35, 0);
    phase(3'd1, 1'b1, 0, 0, 1'b0, 50, 35, 0);
    phase(3'd5, 1'b0, 0, 0, 1'b0, 50, 35, 0);

    settle();
    @(negedge clk);
    if (fails == 0) begin
      $display("multi_reader_audio_ring verification clean");
    end else begin
      $display("multi_reader_audio_ring verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/mrar_pkg.sv
src/mrar_if.sv
src/mrar_front.sv
src/mrar_cmd_queue.sv
src/mrar_back.sv
src/multi_reader_audio_ring.sv
tb/sv/mrar_ring_check.sv
tb/sv/tb.sv
